>>> rtl/hsfd_pkg.sv
// shared types and constants of the humidity sensor frame decoder
package hsfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // one finished frame handed from the parser to the conversion pipeline
  typedef struct packed {
    logic        crc_ok;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
  } job_t;

  // queue status seen by the top level and the conversion pipeline
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // crc-8, msb first, no reflection, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/hsfd_front.sv
// frame parser: byte count, word crc checks and job generation
module hsfd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  input  logic [7:0]           data_byte,
  input  logic                 frame_start,
  output logic                 job_push,
  output hsfd_pkg::job_t       job
);
  import hsfd_pkg::*;

  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  logic [2:0]  byte_index;
  logic [2:0]  byte_index_next;
  logic [7:0]  running_crc;
  logic [7:0]  running_crc_next;
  logic [15:0] temp_word;
  logic [7:0]  hum_high_byte;
  logic        temp_crc_good;
  logic [15:0] hum_word;
  logic [2:0]  pos;
  logic [7:0]  crc_step;

  // frame_start and any stray index value fall back to byte zero
  assign pos      = frame_start ? POS_TEMP_HI : byte_index;
  assign crc_step = crc8_byte(running_crc, data_byte);

  always_comb begin
    byte_index_next  = byte_index;
    running_crc_next = running_crc;
    case (pos)
      POS_TEMP_LO: begin
        byte_index_next  = POS_TEMP_CRC;
        running_crc_next = crc_step;
      end
      POS_TEMP_CRC: begin
        byte_index_next  = POS_HUM_HI;
        running_crc_next = CRC_INIT;
      end
      POS_HUM_HI: begin
        byte_index_next  = POS_HUM_LO;
        running_crc_next = crc_step;
      end
      POS_HUM_LO: begin
        byte_index_next  = POS_HUM_CRC;
        running_crc_next = crc_step;
      end
      POS_HUM_CRC: begin
        byte_index_next  = POS_TEMP_HI;
        running_crc_next = CRC_INIT;
      end
      default: begin
        byte_index_next  = POS_TEMP_LO;
        running_crc_next = crc8_byte(CRC_INIT, data_byte);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= POS_TEMP_HI;
      running_crc <= CRC_INIT;
    end else if (byte_valid) begin
      byte_index  <= byte_index_next;
      running_crc <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid) begin
      case (pos)
        POS_TEMP_LO:  temp_word[7:0] <= data_byte;
        POS_TEMP_CRC: temp_crc_good  <= (data_byte == running_crc);
        POS_HUM_HI:   hum_high_byte  <= data_byte;
        POS_HUM_LO:   hum_word       <= {hum_high_byte, data_byte};
        POS_HUM_CRC:  ;
        default:      temp_word      <= {data_byte, 8'h00};
      endcase
    end
  end

  assign job_push      = byte_valid && (pos == POS_HUM_CRC);
  assign job.crc_ok    = temp_crc_good && (data_byte == running_crc);
  assign job.temp_raw  = temp_word;
  assign job.hum_raw   = hum_word;

endmodule

>>> rtl/hsfd_queue.sv
// two-entry job queue between parser and conversion pipeline
module hsfd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  hsfd_pkg::job_t        push_job,
  input  logic                  pop,
  output hsfd_pkg::job_t        head_job,
  output hsfd_pkg::queue_status_t status
);
  import hsfd_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

endmodule

>>> rtl/hsfd_back.sv
// conversion pipeline: raw words to scaled temperature and humidity
module hsfd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  hsfd_pkg::job_t         head_job,
  input  hsfd_pkg::queue_status_t status,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   crc_ok,
  output logic signed [21:0]     temperature,
  output logic [19:0]            humidity
);
  import hsfd_pkg::*;

  // 1750000 = 26*65535 + 46090, 1000000 = 15*65535 + 16975
  localparam logic [15:0] TEMP_FRAC = 16'd46090;
  localparam logic [15:0] HUM_FRAC  = 16'd16975;
  localparam logic [4:0]  TEMP_INT  = 5'd26;
  localparam logic [4:0]  HUM_INT   = 5'd15;
  localparam logic [16:0] DIVISOR   = 17'd65535;
  localparam logic signed [22:0] TEMP_OFFSET = 23'sd450000;

  logic        advance;
  logic        v1, v2;

  // stage 1
  logic        ok1;
  logic [31:0] prod_t;
  logic [31:0] prod_h;
  logic [20:0] base_t1;
  logic [19:0] base_h1;

  // stage 2
  logic        ok2;
  logic [15:0] q_t;
  logic        rem_nz_t;
  logic [15:0] q_h;
  logic [20:0] base_t2;
  logic [19:0] base_h2;

  logic [16:0] r0_t, r0_h;
  logic        ge_t, ge_h;
  logic signed [22:0] floor_t;
  logic signed [22:0] trunc_t;

  assign advance = !out_valid || out_ready;
  assign pop     = advance && !status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= !status.empty;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // stage 1: fractional products and integer parts
  always_ff @(posedge clk) begin
    if (advance) begin
      ok1     <= head_job.crc_ok;
      prod_t  <= head_job.temp_raw * TEMP_FRAC;
      prod_h  <= head_job.hum_raw * HUM_FRAC;
      base_t1 <= 21'(head_job.temp_raw) * 21'(TEMP_INT);
      base_h1 <= 20'(head_job.hum_raw) * 20'(HUM_INT);
    end
  end

  // stage 2: divide by 65535 as split, fold and one correction
  assign r0_t = {1'b0, prod_t[15:0]} + {1'b0, prod_t[31:16]};
  assign r0_h = {1'b0, prod_h[15:0]} + {1'b0, prod_h[31:16]};
  assign ge_t = (r0_t >= DIVISOR);
  assign ge_h = (r0_h >= DIVISOR);

  always_ff @(posedge clk) begin
    if (advance) begin
      ok2      <= ok1;
      q_t      <= prod_t[31:16] + {15'd0, ge_t};
      rem_nz_t <= ge_t ? (r0_t != DIVISOR) : (r0_t != 17'd0);
      q_h      <= prod_h[31:16] + {15'd0, ge_h};
      base_t2  <= base_t1;
      base_h2  <= base_h1;
    end
  end

  // stage 3: offset, round toward zero, blank on crc failure
  assign floor_t = $signed({2'b00, base_t2}) - TEMP_OFFSET + $signed({7'd0, q_t});
  assign trunc_t = floor_t + ((floor_t < 0 && rem_nz_t) ? 23'sd1 : 23'sd0);

  always_ff @(posedge clk) begin
    if (advance) begin
      crc_ok      <= ok2;
      temperature <= ok2 ? trunc_t[21:0] : 22'sd0;
      humidity    <= ok2 ? (base_h2 + {4'd0, q_h}) : 20'd0;
    end
  end

endmodule

>>> rtl/humidity_sensor_frame_decode.sv
// top level of the humidity sensor measurement frame decoder
//
//  channel | dir | tdata                          | tuser        | meaning
//  s_*     | in  | [7:0] data_byte                | [0] frame_start | one frame byte
//  m_*     | out | [21:0] temperature, [41:22]    | [0] crc_ok   | one decoded frame
//          |     | humidity, [47:42] zero         |              |
//
// one byte is taken per cycle while s_tready is high; frames follow each other with no gap
// a result is offered once the frame has passed the queue write and the three stages
// of the conversion pipeline
// rst clears the byte count, the crc, the queue and every pipeline valid flag
// s_tready falls only while the queue holds two frames;
// a stalled output freezes the whole conversion pipeline in place
module humidity_sensor_frame_decode (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [21:0] temperature, [41:22] humidity, [47:42] zero
  output logic        m_tuser    // [0] crc_ok
);
  import hsfd_pkg::*;

  logic              byte_valid;
  logic              job_push;
  job_t              new_job;
  job_t              head_job;
  queue_status_t     status;
  logic              pop;
  logic signed [21:0] temperature;
  logic [19:0]       humidity;

  // a byte transfers only when a finished frame is sure to find room
  assign s_tready   = !status.full;
  assign byte_valid = s_tvalid && s_tready;

  hsfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .data_byte   (s_tdata),
    .frame_start (s_tuser),
    .job_push    (job_push),
    .job         (new_job)
  );

  hsfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (new_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (status)
  );

  hsfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_job    (head_job),
    .status      (status),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .crc_ok      (m_tuser),
    .temperature (temperature),
    .humidity    (humidity)
  );

  assign m_tdata = {6'd0, humidity, temperature};

endmodule

>>> rtl/hsfd_checker.sv
// port-level checks of the frame decoder, bound to the top level
module hsfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // a failed frame carries zero values
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[41:0] == 42'd0)
    else $error("crc failure with non-zero values");

  // humidity stays within full scale
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[41:22] <= 20'd1000000)
    else $error("humidity above full scale");

  // temperature stays within the sensor range
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[21:0]) >= -22'sd450000)
              && ($signed(m_tdata[21:0]) <= 22'sd1300000))
    else $error("temperature out of range");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered straight after reset");

endmodule

bind humidity_sensor_frame_decode hsfd_checker u_hsfd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> sim/tb_humidity_sensor_frame_decode.sv
// self-checking testbench for the humidity sensor measurement frame decoder
`timescale 1ns / 1ps

module tb_humidity_sensor_frame_decode;
  import hsfd_pkg::*;

  // one decoded frame as the block should report it
  typedef struct {
    logic               crc_ok;
    logic signed [21:0] temperature;
    logic [19:0]        humidity;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] data_byte
  logic        s_tuser;   // [0] frame_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;   // [21:0] temperature, [41:22] humidity, [47:42] zero
  logic        m_tuser;   // [0] crc_ok

  // decoder state mirrored by the predictor
  logic [2:0]  frame_pos;
  logic [7:0]  crc_acc;
  logic [15:0] temp_raw_w;
  logic [7:0]  hum_hi;
  logic        temp_crc_pass;
  logic [15:0] hum_raw_w;

  reading_t    pending_readings[$];

  int          send_gap_pct;
  int          recv_stall_pct;
  int          errors;
  int          bytes_sent;
  int          readings_checked;
  int          frames_good;
  int          frames_rejected;
  logic        needs_resync;

  humidity_sensor_frame_decode i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // receiver back-pressure, changed on the falling edge only
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // crc-8 over one byte, shifting out the top bit each step
  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] din);
    logic [7:0] r;
    logic       fb;
    r = acc ^ din;
    for (int k = 0; k < 8; k++) begin
      fb = r[7];
      r  = r << 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // exact integer conversions, division truncates toward zero
  function automatic logic signed [21:0] scale_temperature(input logic [15:0] raw);
    longint num;
    num = longint'(raw) * 1750000 - longint'(450000) * 65535;
    return 22'(num / 65535);
  endfunction

  function automatic logic [19:0] scale_humidity(input logic [15:0] raw);
    return 20'((longint'(raw) * 1000000) / 65535);
  endfunction

  task automatic clear_decoder_model();
    frame_pos     = 3'd0;
    crc_acc       = CRC_INIT;
    temp_raw_w    = 16'h0000;
    hum_hi        = 8'h00;
    temp_crc_pass = 1'b0;
    hum_raw_w     = 16'h0000;
  endtask

  // advance the mirrored decoder by one accepted byte
  task automatic predict_byte(input logic [7:0] b, input logic start);
    logic [2:0] pos;
    reading_t   r;
    pos = start ? 3'd0 : frame_pos;
    if (pos > 3'd5) begin
      pos = 3'd0;   // out-of-range index restarts the frame
    end
    case (pos)
      3'd0: begin
        crc_acc    = crc_step(CRC_INIT, b);
        temp_raw_w = {b, 8'h00};
        frame_pos  = 3'd1;
      end
      3'd1: begin
        crc_acc    = crc_step(crc_acc, b);
        temp_raw_w = {temp_raw_w[15:8], b};
        frame_pos  = 3'd2;
      end
      3'd2: begin
        temp_crc_pass = (b == crc_acc);
        crc_acc       = CRC_INIT;
        frame_pos     = 3'd3;
      end
      3'd3: begin
        crc_acc   = crc_step(crc_acc, b);
        hum_hi    = b;
        frame_pos = 3'd4;
      end
      3'd4: begin
        crc_acc   = crc_step(crc_acc, b);
        hum_raw_w = {hum_hi, b};
        frame_pos = 3'd5;
      end
      default: begin
        r.crc_ok      = temp_crc_pass && (b == crc_acc);
        r.temperature = r.crc_ok ? scale_temperature(temp_raw_w) : 22'sd0;
        r.humidity    = r.crc_ok ? scale_humidity(hum_raw_w) : 20'd0;
        pending_readings.push_back(r);
        if (r.crc_ok) begin
          frames_good++;
        end else begin
          frames_rejected++;
        end
        crc_acc   = CRC_INIT;
        frame_pos = 3'd0;
      end
    endcase
  endtask

  // one byte transfer on the input channel, with random idle cycles in front
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    do begin
      @(posedge clk);
    end while (!s_tready);
    predict_byte(b, start);
    bytes_sent++;
  endtask

  // six-byte frame; a nonzero flip mask corrupts the matching crc byte
  task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
                            input logic lead_start,
                            input logic [7:0] temp_flip, input logic [7:0] hum_flip);
    logic [7:0] tc;
    logic [7:0] hc;
    tc = crc_step(crc_step(CRC_INIT, tw[15:8]), tw[7:0]);
    hc = crc_step(crc_step(CRC_INIT, hw[15:8]), hw[7:0]);
    send_byte(tw[15:8], lead_start);
    send_byte(tw[7:0], 1'b0);
    send_byte(tc ^ temp_flip, 1'b0);
    send_byte(hw[15:8], 1'b0);
    send_byte(hw[7:0], 1'b0);
    send_byte(hc ^ hum_flip, 1'b0);
  endtask

  // compare every result transfer against the oldest pending reading
  always @(posedge clk) begin
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: result expected none, actual crc_ok=%0b temp=%0d hum=%0d", $time,
                 m_tuser, $signed(m_tdata[21:0]), m_tdata[41:22]);
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (m_tuser !== want.crc_ok) begin
          errors++;
          $display("%0t: crc_ok expected %0b actual %0b", $time, want.crc_ok, m_tuser);
        end
        if (m_tdata[21:0] !== want.temperature) begin
          errors++;
          $display("%0t: temperature expected %0d actual %0d", $time,
                   want.temperature, $signed(m_tdata[21:0]));
        end
        if (m_tdata[41:22] !== want.humidity) begin
          errors++;
          $display("%0t: humidity expected %0d actual %0d", $time,
                   want.humidity, m_tdata[41:22]);
        end
        if (m_tdata[47:42] !== 6'd0) begin
          errors++;
          $display("%0t: tdata padding expected 0 actual %b", $time, m_tdata[47:42]);
        end
      end
    end
  end

  // lowest and highest raw words, both with good crcs
  task automatic test_range_extremes();
    send_frame(16'h0000, 16'h0000, 1'b1, 8'h00, 8'h00);
    send_frame(16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 8'h00);
  endtask

  // temperature crc wrong, humidity crc fine: values must read zero
  task automatic test_temp_crc_failure();
    send_frame(16'h1234, 16'h5678, 1'b0, 8'h80, 8'h00);
  endtask

  // partial frame abandoned, then frame_start restarts the count; humidity crc wrong
  task automatic test_frame_resync();
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_frame(16'h6666, 16'h8000, 1'b1, 8'h00, 8'h01);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly well-formed frames with random words, some broken crcs, some noise
  task automatic test_random_traffic(input int n_bytes);
    int     stop_at;
    int     kind;
    int     n_noise;
    logic   lead;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(99);
      lead = needs_resync ? 1'b1 : 1'($urandom_range(1));
      if (kind < 75) begin
        send_frame(pick_word(), pick_word(), lead, 8'h00, 8'h00);
        needs_resync = 1'b0;
      end else if (kind < 88) begin
        // corrupt one or both crc bytes by a random nonzero pattern
        case ($urandom_range(2))
          0:       send_frame(pick_word(), pick_word(), lead,
                              8'($urandom_range(1, 255)), 8'h00);
          1:       send_frame(pick_word(), pick_word(), lead,
                              8'h00, 8'($urandom_range(1, 255)));
          default: send_frame(pick_word(), pick_word(), lead,
                              8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
        endcase
        needs_resync = 1'b0;
      end else begin
        // short burst of stray bytes with random frame_start, may complete a frame
        n_noise = $urandom_range(1, 5);
        repeat (n_noise) begin
          send_byte(8'($urandom), 1'($urandom_range(1)));
        end
        needs_resync = 1'b1;
      end
    end
  endtask

  initial begin
    int drain_cycles;
    errors           = 0;
    bytes_sent       = 0;
    readings_checked = 0;
    frames_good      = 0;
    frames_rejected  = 0;
    needs_resync     = 1'b0;
    send_gap_pct     = 35;
    recv_stall_pct   = 52;
    rst              = 1'b1;
    s_tvalid         = 1'b0;
    s_tdata          = 8'h00;
    s_tuser          = 1'b0;
    clear_decoder_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_range_extremes();
    test_temp_crc_failure();
    test_frame_resync();

    test_random_traffic(584);
    send_gap_pct   = 52;
    recv_stall_pct = 35;
    test_random_traffic(584);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_traffic(584);

    @(negedge clk);
    s_tvalid <= 1'b0;

    // let the pipeline drain, then keep watching for anything stray
    drain_cycles = 0;
    while (pending_readings.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (20) @(posedge clk);
    if (pending_readings.size() != 0) begin
      errors++;
      $display("%0t: outstanding readings expected 0 actual %0d", $time,
               pending_readings.size());
    end

    $display("sent %0d bytes; checked %0d readings (%0d good crc, %0d rejected)",
             bytes_sent, readings_checked, frames_good, frames_rejected);
    $display("covered raw word extremes, crc faults, resync on frame_start, three stall mixes");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("%0t: watchdog expired", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> humidity_sensor_frame_decode.f
rtl/hsfd_pkg.sv
rtl/hsfd_front.sv
rtl/hsfd_queue.sv
rtl/hsfd_back.sv
rtl/humidity_sensor_frame_decode.sv
rtl/hsfd_checker.sv
sim/tb_humidity_sensor_frame_decode.sv
